// ===== design/wf23_pkg.sv =====
// ----------------------------------------------------------------------------
// wf23_pkg
// Shared types and IEEE binary32 arithmetic for the Winograd F(2,3) tile MAC.
// ----------------------------------------------------------------------------
package wf23_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] HALF      = 32'h3F00_0000;

    localparam logic MODE_1X1  = 1'b0;
    localparam logic MODE_WINO = 1'b1;

    // Operands of one tile as it moves down the pipeline. The meaning of the
    // x and w lanes changes from stage to stage.
    typedef struct packed {
        logic        mode;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] p0;
        logic [31:0] p1;
    } t_tile;

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic              s;
        logic [7:0]        ea;
        logic [7:0]        eb;
        logic [23:0]       ma;
        logic [23:0]       mb;
        logic [47:0]       p;
        logic [5:0]        lz;
        logic signed [11:0] e;
        logic [11:0]       rs;
        logic [95:0]       ext;
        logic [23:0]       m24;
        logic              g;
        logic              st;
        logic              rnd;
        logic [7:0]        fld;
        logic [31:0]       res;
        s   = a[31] ^ b[31];
        ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma  = {|a[30:23], a[22:0]};
        mb  = {|b[30:23], b[22:0]};
        p   = ma * mb;
        lz  = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (p[i]) begin
                lz = 6'(47 - i);
            end
        end
        p   = p << lz;
        e   = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
        ext = {p, 48'd0};
        fld = 8'd0;
        if (e > 12'sd0) begin
            fld = e[7:0];
        end else begin
            rs = 12'(12'sd1 - e);
            if (rs > 12'd48) begin
                rs = 12'd48;
            end
            ext = ext >> rs;
        end
        m24 = ext[95:72];
        g   = ext[71];
        st  = |ext[70:0];
        rnd = g & (st | m24[0]);
        res = {s, 31'({fld, m24[22:0]} + {30'd0, rnd})};
        if (e >= 12'sd255) begin
            res = {s, 8'hFF, 23'd0};
        end
        if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0)) begin
            res = CANON_NAN;
        end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
                res = CANON_NAN;
            end else begin
                res = {s, 8'hFF, 23'd0};
            end
        end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            res = {s, 31'd0};
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] mx;
        logic [53:0] ext;
        logic [26:0] my;
        logic        sub;
        logic [27:0] sum;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [9:0]  sh;
        logic [23:0] m24;
        logic        g;
        logic        st;
        logic        rnd;
        logic [7:0]  fld;
        logic [31:0] res;
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d   = ex - ey;
        if (d > 8'd27) begin
            d = 8'd27;
        end
        mx  = {|x[30:23], x[22:0], 3'd0};
        ext = {|y[30:23], y[22:0], 3'd0, 27'd0} >> d;
        my  = {ext[53:28], ext[27] | (|ext[26:0])};
        sub = x[31] ^ y[31];
        sum = sub ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
        e   = {2'd0, ex};
        if (sum[27]) begin
            sum = {1'b0, sum[27:2], sum[1] | sum[0]};
            e   = e + 10'd1;
        end else begin
            lz = 5'd0;
            for (int i = 0; i < 27; i++) begin
                if (sum[i]) begin
                    lz = 5'(26 - i);
                end
            end
            sh  = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
            sum = sum << sh;
            e   = e - sh;
        end
        m24 = sum[26:3];
        g   = sum[2];
        st  = |sum[1:0];
        rnd = g & (st | m24[0]);
        fld = sum[26] ? e[7:0] : 8'd0;
        res = {x[31], 31'({fld, m24[22:0]} + {30'd0, rnd})};
        if (e >= 10'd255) begin
            res = {x[31], 8'hFF, 23'd0};
        end
        if (sum == 28'd0) begin
            res = {(sub ? 1'b0 : x[31]), 31'd0};
        end
        if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0)) begin
            res = CANON_NAN;
        end else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) begin
            res = (a[31] != b[31]) ? CANON_NAN : a;
        end else if (a[30:23] == 8'hFF) begin
            res = a;
        end else if (b[30:23] == 8'hFF) begin
            res = b;
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_add(a, {~b[31], b[30:0]});
    endfunction

endpackage

// ===== design/wf23_xform.sv =====
// ----------------------------------------------------------------------------
// wf23_xform
// Input and weight transforms: three register stages (adds, adds, halving).
// ----------------------------------------------------------------------------
module wf23_xform (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  wf23_pkg::t_tile i_tile,
    output logic           o_vld,
    output wf23_pkg::t_tile o_tile
);
    import wf23_pkg::*;

    logic [2:0] r_vld;
    t_tile      r_s1;
    t_tile      r_s2;
    t_tile      r_s3;
    t_tile      n_s1;
    t_tile      n_s2;
    t_tile      n_s3;

    always_comb begin
        n_s1 = i_tile;
        if (i_tile.mode == MODE_WINO) begin
            n_s1.x0 = fp_sub(i_tile.x0, i_tile.x2);
            n_s1.x1 = fp_add(i_tile.x1, i_tile.x2);
            n_s1.x2 = fp_sub(i_tile.x2, i_tile.x1);
            n_s1.x3 = fp_sub(i_tile.x1, i_tile.x3);
            n_s1.w1 = fp_add(i_tile.w0, i_tile.w1);
            n_s1.w2 = fp_sub(i_tile.w0, i_tile.w1);
        end else begin
            // Both 1x1 products share the single weight.
            n_s1.x0 = i_tile.x1;
            n_s1.x1 = i_tile.x2;
            n_s1.w1 = i_tile.w0;
        end
    end

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.mode == MODE_WINO) begin
            n_s2.w1 = fp_add(r_s1.w1, r_s1.w3);
            n_s2.w2 = fp_add(r_s1.w2, r_s1.w3);
        end
    end

    always_comb begin
        n_s3 = r_s2;
        if (r_s2.mode == MODE_WINO) begin
            n_s3.w1 = fp_mul(r_s2.w1, HALF);
            n_s3.w2 = fp_mul(r_s2.w2, HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'd0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_tile = r_s3;

endmodule

// ===== design/wf23_mul.sv =====
// ----------------------------------------------------------------------------
// wf23_mul
// Element-wise products of transformed samples and weights, one stage.
// ----------------------------------------------------------------------------
module wf23_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  wf23_pkg::t_tile i_tile,
    output logic           o_vld,
    output wf23_pkg::t_tile o_tile
);
    import wf23_pkg::*;

    logic  r_vld;
    t_tile r_tile;
    t_tile n_tile;

    always_comb begin
        n_tile    = i_tile;
        n_tile.x0 = fp_mul(i_tile.x0, i_tile.w0);
        n_tile.x1 = fp_mul(i_tile.x1, i_tile.w1);
        n_tile.x2 = fp_mul(i_tile.x2, i_tile.w2);
        n_tile.x3 = fp_mul(i_tile.x3, i_tile.w3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tile <= n_tile;
        end
    end

    assign o_vld  = r_vld;
    assign o_tile = r_tile;

endmodule

// ===== design/wf23_comb.sv =====
// ----------------------------------------------------------------------------
// wf23_comb
// Output transform of the four products and accumulation into the partials.
// ----------------------------------------------------------------------------
module wf23_comb (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  wf23_pkg::t_tile i_tile,
    output logic           o_vld,
    output logic [31:0]    o_sum_out_0,
    output logic [31:0]    o_sum_out_1
);
    import wf23_pkg::*;

    logic [2:0]  r_vld;
    t_tile       r_s5;
    t_tile       r_s6;
    t_tile       n_s5;
    t_tile       n_s6;
    logic [31:0] r_sum0;
    logic [31:0] r_sum1;

    always_comb begin
        n_s5 = i_tile;
        if (i_tile.mode == MODE_WINO) begin
            n_s5.x0 = fp_add(i_tile.x0, i_tile.x1);
            n_s5.x1 = fp_sub(i_tile.x1, i_tile.x2);
        end
    end

    always_comb begin
        n_s6 = r_s5;
        if (r_s5.mode == MODE_WINO) begin
            n_s6.x0 = fp_add(r_s5.x0, r_s5.x2);
            n_s6.x1 = fp_sub(r_s5.x1, r_s5.x3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'd0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s5   <= n_s5;
            r_s6   <= n_s6;
            r_sum0 <= fp_add(r_s6.p0, r_s6.x0);
            r_sum1 <= fp_add(r_s6.p1, r_s6.x1);
        end
    end

    assign o_vld       = r_vld[2];
    assign o_sum_out_0 = r_sum0;
    assign o_sum_out_1 = r_sum1;

endmodule

// ===== design/winograd_f2_3_tile_mac.sv =====
// Stages in order: transform, product, output transform, accumulation.
// Throughput: one tile per cycle unless the output stalls; the single
// floating-point operation in each of the seven stages sets the clock period.
// The whole pipeline freezes while the output beat waits to be taken.
// Reset (synchronous, active low) empties the pipeline and sets 3-tap mode.
// ----------------------------------------------------------------------------
// winograd_f2_3_tile_mac
// Single-precision Winograd F(2,3) tile multiply-accumulate, fully pipelined.
// ----------------------------------------------------------------------------
module winograd_f2_3_tile_mac (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,  // kernel_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_0, sample_1, sample_2, sample_3, tap_0, tap_1, tap_2,
    // partial_in_0, partial_in_1 (32 bits each, lowest first)
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sum_out_0, sum_out_1 (32 bits each, lowest first)
    output logic [63:0]  m_axis_tdata
);
    import wf23_pkg::*;

    logic  r_mode;
    logic  ce;
    t_tile in_tile;
    logic  xf_vld;
    t_tile xf_tile;
    logic  mul_vld;
    t_tile mul_tile;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WINO;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    always_comb begin
        in_tile.mode = r_mode;
        in_tile.x0   = s_axis_tdata[31:0];
        in_tile.x1   = s_axis_tdata[63:32];
        in_tile.x2   = s_axis_tdata[95:64];
        in_tile.x3   = s_axis_tdata[127:96];
        in_tile.w0   = s_axis_tdata[159:128];
        in_tile.w1   = s_axis_tdata[191:160];
        in_tile.w2   = s_axis_tdata[223:192];
        in_tile.w3   = s_axis_tdata[223:192];
        in_tile.p0   = s_axis_tdata[255:224];
        in_tile.p1   = s_axis_tdata[287:256];
    end

    wf23_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_axis_tvalid),
        .i_tile  (in_tile),
        .o_vld   (xf_vld),
        .o_tile  (xf_tile)
    );

    wf23_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (xf_vld),
        .i_tile  (xf_tile),
        .o_vld   (mul_vld),
        .o_tile  (mul_tile)
    );

    wf23_comb u_comb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (ce),
        .i_vld       (mul_vld),
        .i_tile      (mul_tile),
        .o_vld       (m_axis_tvalid),
        .o_sum_out_0 (m_axis_tdata[31:0]),
        .o_sum_out_1 (m_axis_tdata[63:32])
    );

`ifndef SYNTH
    // A stalled output freezes every stage valid bit that is visible here.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable({xf_vld, mul_vld, m_axis_tvalid}))
        else $error("pipeline moved during an output stall");

    // Any NaN leaving the block is the canonical quiet NaN.
    a_canon_nan0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[30:23] == 8'hFF && m_axis_tdata[22:0] != 23'd0
        |-> m_axis_tdata[31:0] == CANON_NAN)
        else $error("non-canonical NaN on sum_out_0");

    a_canon_nan1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[62:55] == 8'hFF && m_axis_tdata[54:32] != 23'd0
        |-> m_axis_tdata[63:32] == CANON_NAN)
        else $error("non-canonical NaN on sum_out_1");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !xf_vld && !mul_vld)
        else $error("beat survived reset");
`endif

endmodule

// ===== bench/wf23_tile_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf23_tile_checker
// Watches the tile and sum streams of the Winograd F(2,3) MAC, predicts the
// two updated sums of every accepted tile in binary32 integer arithmetic and
// compares them, in order, with the sum beats that leave the block.
// ----------------------------------------------------------------------------
module wf23_tile_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [287:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,
    output int           o_fails,
    output int           o_pending
);
    import wf23_pkg::*;

    logic        kernel_mode;
    logic [63:0] sums_due[$];

    function automatic bit is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 23'd0;
    endfunction

    function automatic bit is_inf(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == 23'd0;
    endfunction

    // Rounds sign * mag * 2^exp2 to the nearest binary32, ties to even.
    function automatic logic [31:0] round_to_single(bit sgn, int exp2, logic [63:0] mag);
        int           msb;
        int           shift;
        logic [127:0] ext;
        logic [63:0]  q;
        bit           g;
        bit           st;
        longint       v;
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) msb = i;
        end
        shift = msb - 23;
        if (shift < -149 - exp2) shift = -149 - exp2;
        if (shift >= 128) begin
            q = 64'd0;
            g = 1'b0;
            st = 1'b1;
        end else if (shift > 0) begin
            ext = {mag, 64'd0} >> shift;
            q = ext[127:64];
            g = ext[63];
            st = |ext[62:0];
        end else begin
            q = mag << (-shift);
            g = 1'b0;
            st = 1'b0;
        end
        if (g && (st || q[0])) q = q + 64'd1;
        // With q holding the hidden bit, the carry into the exponent field
        // comes out of the addition by itself.
        v = longint'(exp2 + shift + 149) * 64'sd8388608 + longint'(q);
        if (v >= 64'sh7F80_0000) return {sgn, 8'hFF, 23'd0};
        return {sgn, v[30:0]};
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        int          ea;
        int          eb;
        int          base;
        int          d;
        longint      ma;
        longint      mb;
        longint      tmp;
        longint      s;
        bit          sa;
        bit          sb;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        sa = a[31];
        sb = b[31];
        ma = longint'({|a[30:23], a[22:0]});
        mb = longint'({|b[30:23], b[22:0]});
        ea = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
        eb = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
        if (eb > ea) begin
            tmp = ma; ma = mb; mb = tmp;
            d = ea; ea = eb; eb = d;
            sa = b[31];
            sb = a[31];
        end
        d = ea - eb;
        base = eb;
        // A far smaller operand only matters as a sticky bit.
        if (d > 30) begin
            d = 30;
            mb = (mb != 0) ? 1 : 0;
            base = ea - 30;
        end
        s = (sa ? -(ma <<< d) : (ma <<< d)) + (sb ? -mb : mb);
        if (s == 0) return 32'd0;
        return round_to_single(s < 0, base, 64'(s < 0 ? -s : s));
    endfunction

    function automatic logic [31:0] f32_sub(logic [31:0] a, logic [31:0] b);
        return f32_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        bit          sgn;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
            return {sgn, 8'hFF, 23'd0};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
        ma = 64'({|a[30:23], a[22:0]});
        mb = 64'({|b[30:23], b[22:0]});
        ea = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
        eb = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
        return round_to_single(sgn, ea + eb, ma * mb);
    endfunction

    function automatic logic [63:0] tile_sums(logic mode, logic [287:0] t);
        logic [31:0] d[4];
        logic [31:0] g[3];
        logic [31:0] y0;
        logic [31:0] y1;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] m0;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] m3;
        for (int i = 0; i < 4; i++) d[i] = t[32*i +: 32];
        for (int i = 0; i < 3; i++) g[i] = t[128 + 32*i +: 32];
        if (mode == MODE_WINO) begin
            w1 = f32_mul(f32_add(f32_add(g[0], g[1]), g[2]), HALF);
            w2 = f32_mul(f32_add(f32_sub(g[0], g[1]), g[2]), HALF);
            m0 = f32_mul(f32_sub(d[0], d[2]), g[0]);
            m1 = f32_mul(f32_add(d[1], d[2]), w1);
            m2 = f32_mul(f32_sub(d[2], d[1]), w2);
            m3 = f32_mul(f32_sub(d[1], d[3]), g[2]);
            y0 = f32_add(f32_add(m0, m1), m2);
            y1 = f32_sub(f32_sub(m1, m2), m3);
        end else begin
            y0 = f32_mul(d[1], g[0]);
            y1 = f32_mul(d[2], g[0]);
        end
        return {f32_add(t[287:256], y1), f32_add(t[255:224], y0)};
    endfunction

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            kernel_mode <= MODE_WINO;
            o_fails <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) kernel_mode <= i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) sums_due.push_back(tile_sums(kernel_mode, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (sums_due.size() == 0) begin
                    if (o_fails < 10) $display("unexpected sum beat %h", i_m_tdata);
                    o_fails <= o_fails + 1;
                end else begin
                    want = sums_due.pop_front();
                    if (want != i_m_tdata) begin
                        if (o_fails < 10) begin
                            $display("sum mismatch: sum_out_0 exp %h got %h, sum_out_1 exp %h got %h",
                                     want[31:0], i_m_tdata[31:0], want[63:32], i_m_tdata[63:32]);
                        end
                        o_fails <= o_fails + 1;
                    end
                end
            end
            o_pending <= sums_due.size();
        end
    end

endmodule

// ===== bench/tb_winograd_f2_3_tile_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_winograd_f2_3_tile_mac
// Feeds directed and random tiles in both kernel modes through the tile MAC
// with bursty input and a stalling sink; the checker judges every sum beat.
// ----------------------------------------------------------------------------
module tb_winograd_f2_3_tile_mac;
    import wf23_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_wr_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    int           fails;
    int           pending;
    int           cycles = 0;

    winograd_f2_3_tile_mac i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wf23_tile_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_fails       (fails),
        .o_pending     (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sink: stall density is redrawn periodically, and once it holds off for
    // a long stretch so that the pipeline fills and back-pressures the input.
    int stall_pct = 0;
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) stall_pct <= $urandom_range(0, 3) * 25;
        if (cycles >= 500 && cycles < 900) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    const logic [31:0] odd_values[12] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
        32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000, 32'h3F80_0000
    };

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return odd_values[$urandom_range(0, 11)];
            default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [287:0] random_tile();
        logic [287:0] t;
        for (int i = 0; i < 9; i++) t[32*i +: 32] = pick_value();
        return t;
    endfunction

    // A tile whose fields all hold the same value, with one lane overridden.
    function automatic logic [287:0] flat_tile(logic [31:0] v, int lane, logic [31:0] w);
        logic [287:0] t;
        for (int i = 0; i < 9; i++) t[32*i +: 32] = v;
        t[32*lane +: 32] = w;
        return t;
    endfunction

    task automatic send_tile(logic [287:0] t);
        bit taken;
        s_axis_tdata <= t;
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic send_random(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_tile(random_tile());
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // The pending count is looked at between edges, once the checker has
    // booked every beat of the last edge.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic mode);
        wait_drained();
        repeat (10) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_directed();
        for (int v = 0; v < 12; v++) send_tile(flat_tile(odd_values[v], v % 9, 32'h3F80_0000));
        send_tile(flat_tile(32'h3F80_0000, 0, 32'h7F80_0000));
        send_tile(flat_tile(32'h7F80_0000, 1, 32'h0000_0000));
        send_tile(flat_tile(32'h0000_0001, 4, 32'h3F00_0000));
        send_tile(flat_tile(32'h7F7F_FFFF, 8, 32'hFF7F_FFFF));
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        send_random(600);
        set_mode(MODE_1X1);
        send_directed();
        send_random(600);
        set_mode(MODE_WINO);
        send_random(600);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
